// ----- design/pqrs_pkg.sv -----
package pqrs_pkg;

    // Sizes of the two stores. RETX_DEPTH must be a power of two, because a
    // slot is picked by the low bits of the sequence number.
    localparam int QUEUE_DEPTH = 256;
    localparam int RETX_DEPTH  = 4096;

    localparam int QADDR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int RADDR_W = $clog2(RETX_DEPTH);

    // Field widths of the item and the result.
    localparam int OP_W    = 3;
    localparam int REF_W   = 32;
    localparam int SIZE_W  = 16;
    localparam int SEQ_W   = 16;
    localparam int TIME_W  = 32;
    localparam int BYTES_W = 24;

    // Operation codes. Codes six and seven act as a status request.
    localparam logic [OP_W-1:0] OP_PUSH   = OP_W'(0);
    localparam logic [OP_W-1:0] OP_POP    = OP_W'(1);
    localparam logic [OP_W-1:0] OP_NACK   = OP_W'(2);
    localparam logic [OP_W-1:0] OP_ACK    = OP_W'(3);
    localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(4);
    localparam logic [OP_W-1:0] OP_STATUS = OP_W'(5);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [REF_W-1:0]  packet_ref;
        logic [SIZE_W-1:0] pkt_size;
        logic [SEQ_W-1:0]  seq_nr;
        logic [TIME_W-1:0] time_now;
    } t_item;

    typedef struct packed {
        logic               ok;
        logic [REF_W-1:0]   out_ref;
        logic [SIZE_W-1:0]  out_size;
        logic [SEQ_W-1:0]   out_seq;
        logic               head_valid;
        logic [SIZE_W-1:0]  head_size;
        logic [SEQ_W-1:0]   head_seq;
        logic [BYTES_W-1:0] queue_bytes;
        logic [QCNT_W-1:0]  queue_count;
        logic [TIME_W-1:0]  head_age;
        logic               full_reject;
    } t_result;

    // One descriptor in the ring.
    typedef struct packed {
        logic [REF_W-1:0]  buf_ref;
        logic [SIZE_W-1:0] size;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] arrival;
    } t_ring_entry;

    // One slot of the retransmit table.
    typedef struct packed {
        logic              valid;
        logic [SEQ_W-1:0]  seq;
        logic [SIZE_W-1:0] size;
        logic [REF_W-1:0]  buf_ref;
    } t_retx_entry;

    typedef struct packed {
        logic               en;
        logic [QADDR_W-1:0] addr;
        t_ring_entry        data;
    } t_ring_wr;

    typedef struct packed {
        logic               en;
        logic [QADDR_W-1:0] addr;
    } t_ring_rd;

    typedef struct packed {
        logic               en;
        logic [RADDR_W-1:0] addr;
        t_retx_entry        data;
    } t_retx_wr;

    typedef struct packed {
        logic               en;
        logic [RADDR_W-1:0] addr;
    } t_retx_rd;

endpackage

// ----- design/pqrs_if.sv -----
// Item channel into the block.
interface pqrs_in_if import pqrs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [REF_W-1:0]  packet_ref;
    logic [SIZE_W-1:0] pkt_size;
    logic [SEQ_W-1:0]  seq_nr;
    logic [TIME_W-1:0] time_now;

    modport source (output valid, op, packet_ref, pkt_size, seq_nr, time_now, input ready);
    modport sink (input valid, op, packet_ref, pkt_size, seq_nr, time_now, output ready);
endinterface

// Result channel out of the block.
interface pqrs_out_if import pqrs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [REF_W-1:0]   out_ref;
    logic [SIZE_W-1:0]  out_size;
    logic [SEQ_W-1:0]   out_seq;
    logic               head_valid;
    logic [SIZE_W-1:0]  head_size;
    logic [SEQ_W-1:0]   head_seq;
    logic [BYTES_W-1:0] queue_bytes;
    logic [QCNT_W-1:0]  queue_count;
    logic [TIME_W-1:0]  head_age;
    logic               full_reject;

    modport source (
        output valid, ok, out_ref, out_size, out_seq, head_valid, head_size, head_seq,
               queue_bytes, queue_count, head_age, full_reject,
        input  ready
    );
    modport sink (
        input  valid, ok, out_ref, out_size, out_seq, head_valid, head_size, head_seq,
               queue_bytes, queue_count, head_age, full_reject,
        output ready
    );
endinterface

// ----- design/pqrs_ring.sv -----
module pqrs_ring import pqrs_pkg::*; (
    input  logic        i_clk,
    input  t_ring_wr    i_wr,
    input  t_ring_rd    i_rd,
    output t_ring_entry o_rd_data
);

    t_ring_entry r_mem [QUEUE_DEPTH];
    t_ring_entry r_rd_data;

    // Descriptor storage with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/pqrs_retx.sv -----
module pqrs_retx import pqrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_retx_wr    i_wr,
    input  t_retx_rd    i_rd,
    output t_retx_entry o_rd_data,
    output logic        o_busy
);

    t_retx_entry        r_mem [RETX_DEPTH];
    t_retx_entry        r_rd_data;
    logic               r_busy;
    logic [RADDR_W-1:0] r_clr_addr;

    // After reset, sweep the table once to clear every valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == RADDR_W'(RETX_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Table storage; the sweep owns the write port while it runs.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

// ----- design/packet_queue_with_retransmit_store.sv -----
// Packet descriptor queue with a retransmit store. Each item is one operation (push,
// pop, NACK lookup, ACK delete, clear or status) and yields exactly one result that
// also reports the head descriptor, its age against the item's time, the byte total
// and the entry count. In the accept cycle the ring and the retransmit table are
// read; the read data is then used, the stores are written back and the result
// register is loaded, once that register is free. The result register lets a finished
// result wait for the sink while the block stays ready for the next item. After reset
// the block clears the retransmit table's valid flags, one slot per cycle, and accepts
// no item until that sweep is done. A push into a full queue is refused and flagged,
// and a pop overwrites whatever slot its sequence number maps to.
module packet_queue_with_retransmit_store import pqrs_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    pqrs_in_if.sink        i_in,
    pqrs_out_if.source     o_out
);

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic [QADDR_W-1:0] r_rp, n_rp;
    logic [QADDR_W-1:0] r_wp, n_wp;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    t_ring_entry        r_head, n_head;
    logic               r_out_valid, n_out_valid;
    t_result            r_res, n_res;

    t_ring_wr           ring_wr;
    t_ring_rd           ring_rd;
    t_ring_entry        ring_rd_data;
    t_retx_wr           retx_wr;
    t_retx_rd           retx_rd;
    t_retx_entry        retx_rd_data;
    logic               retx_busy;
    logic               in_ready;
    logic [QADDR_W-1:0] rp_next;
    logic [QADDR_W-1:0] wp_next;
    logic               retx_hit;
    t_result            res;

    pqrs_ring u_ring (
        .i_clk     (i_clk),
        .i_wr      (ring_wr),
        .i_rd      (ring_rd),
        .o_rd_data (ring_rd_data)
    );

    pqrs_retx u_retx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (retx_wr),
        .i_rd      (retx_rd),
        .o_rd_data (retx_rd_data),
        .o_busy    (retx_busy)
    );

    // Ring pointer increments with wrap at the queue depth.
    assign rp_next = (r_rp == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign wp_next = (r_wp == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    // A retransmit slot matches when it is valid and holds the item's sequence number.
    assign retx_hit = retx_rd_data.valid && (retx_rd_data.seq == r_item.seq_nr);

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_bytes     <= n_bytes;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: the held item, the cached head descriptor and the result.
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_head <= n_head;
        r_res  <= n_res;
    end

    // Next state, memory requests and the result of the item in progress.
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_count     = r_count;
        n_bytes     = r_bytes;
        n_head      = r_head;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_out.ready;
        ring_wr     = '0;
        ring_rd     = '0;
        retx_wr     = '0;
        retx_rd     = '0;
        in_ready    = 1'b0;
        res         = '0;

        case (r_state)
            S_IDLE: begin
                in_ready = !retx_busy;
                if (in_ready && i_in.valid) begin
                    n_item.op         = i_in.op;
                    n_item.packet_ref = i_in.packet_ref;
                    n_item.pkt_size   = i_in.pkt_size;
                    n_item.seq_nr     = i_in.seq_nr;
                    n_item.time_now   = i_in.time_now;
                    // Prefetch the entry behind the head and the addressed slot.
                    ring_rd.en   = 1'b1;
                    ring_rd.addr = rp_next;
                    retx_rd.en   = 1'b1;
                    retx_rd.addr = i_in.seq_nr[RADDR_W-1:0];
                    n_state      = S_EXEC;
                end
            end

            S_EXEC: begin
                // Commit only once the result register is free.
                if (!r_out_valid || o_out.ready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    case (r_item.op)
                        OP_PUSH: begin
                            if (r_count == QCNT_W'(QUEUE_DEPTH)) begin
                                res.full_reject = 1'b1;
                            end else begin
                                ring_wr.en           = 1'b1;
                                ring_wr.addr         = r_wp;
                                ring_wr.data.buf_ref = r_item.packet_ref;
                                ring_wr.data.size    = r_item.pkt_size;
                                ring_wr.data.seq     = r_item.seq_nr;
                                ring_wr.data.arrival = r_item.time_now;
                                n_wp    = wp_next;
                                n_count = r_count + 1'b1;
                                n_bytes = r_bytes + BYTES_W'(r_item.pkt_size);
                                res.ok  = 1'b1;
                                if (r_count == '0) begin
                                    n_head = ring_wr.data;
                                end
                            end
                        end
                        OP_POP: begin
                            if (r_count != '0) begin
                                res.ok       = 1'b1;
                                res.out_ref  = r_head.buf_ref;
                                res.out_size = r_head.size;
                                res.out_seq  = r_head.seq;
                                // File the popped descriptor for retransmission.
                                retx_wr.en           = 1'b1;
                                retx_wr.addr         = r_head.seq[RADDR_W-1:0];
                                retx_wr.data.valid   = 1'b1;
                                retx_wr.data.seq     = r_head.seq;
                                retx_wr.data.size    = r_head.size;
                                retx_wr.data.buf_ref = r_head.buf_ref;
                                n_rp    = rp_next;
                                n_count = r_count - 1'b1;
                                n_bytes = r_bytes - BYTES_W'(r_head.size);
                                n_head  = ring_rd_data;
                            end
                        end
                        OP_NACK: begin
                            if (retx_hit) begin
                                res.ok       = 1'b1;
                                res.out_ref  = retx_rd_data.buf_ref;
                                res.out_size = retx_rd_data.size;
                            end
                        end
                        OP_ACK: begin
                            if (retx_hit) begin
                                retx_wr.en   = 1'b1;
                                retx_wr.addr = r_item.seq_nr[RADDR_W-1:0];
                                retx_wr.data = '0;
                            end
                        end
                        OP_CLEAR: begin
                            n_rp    = '0;
                            n_wp    = '0;
                            n_count = '0;
                            n_bytes = '0;
                        end
                        default: begin
                        end
                    endcase

                    // Head report reflects the queue after this item.
                    res.queue_bytes = n_bytes;
                    res.queue_count = n_count;
                    if (n_count != '0) begin
                        res.head_valid = 1'b1;
                        res.head_size  = n_head.size;
                        res.head_seq   = n_head.seq;
                        res.head_age   = r_item.time_now - n_head.arrival;
                    end
                    n_res = res;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Port drive.
    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.ok          = r_res.ok;
    assign o_out.out_ref     = r_res.out_ref;
    assign o_out.out_size    = r_res.out_size;
    assign o_out.out_seq     = r_res.out_seq;
    assign o_out.head_valid  = r_res.head_valid;
    assign o_out.head_size   = r_res.head_size;
    assign o_out.head_seq    = r_res.head_seq;
    assign o_out.queue_bytes = r_res.queue_bytes;
    assign o_out.queue_count = r_res.queue_count;
    assign o_out.head_age    = r_res.head_age;
    assign o_out.full_reject = r_res.full_reject;

    // The entry count never passes the ring depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds ring depth");

    // An empty or a full ring has both pointers at the same place.
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)) |-> (r_rp == r_wp))
        else $error("ring pointers disagree with entry count");

    // An empty queue holds no bytes.
    a_empty_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_bytes == '0))
        else $error("byte total nonzero on empty queue");

    // An accepted item always takes the block into its execute state in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_EXEC))
        else $error("accepted item not taken into execution");

endmodule
